### rtl/core/bbcm_pkg.sv
// ----------------------------------------------------------------------------
// bbcm_pkg
// Shared types and codes of the block buffer cache manager.
// ----------------------------------------------------------------------------
package bbcm_pkg;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_FILL    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_MISS    = 3'd1,
    ST_BUSY    = 3'd2,
    ST_NOFREE  = 3'd3,
    ST_WB      = 3'd4,
    ST_DONE    = 3'd5,
    ST_BADIDX  = 3'd6,
    ST_UNUSED  = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_VICTIM,
    S_FREESRCH,
    S_SHIFT,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic scan_clr;   // restart scan counter
    logic scan_step;  // advance scan counter
    logic do_hit;     // lock matched slot, start search for it in free list
    logic do_wb;      // clear dirty of head, rotate head to tail
    logic do_miss;    // retag head, start removal of head
    logic do_release; // release named slot
    logic do_fill;    // set valid of named slot
    logic shift_step; // one step of free list compaction
    logic srch_step;  // one step of free list search
    logic res_load;   // load result register
    logic [2:0] res_st;
    logic res_last;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;  // scan counter went past last slot
    logic match;      // current slot tag equals request block
    logic locked;     // locked bit of current / named slot
    logic head_dirty;
    logic free_empty;
    logic idx_bad;
    logic srch_found;
    logic shift_done;
  } sts_t;

endpackage

### rtl/core/bbcm_datapath.sv
// ----------------------------------------------------------------------------
// bbcm_datapath
// Tag store, state bits, free list and result register.
// ----------------------------------------------------------------------------
module bbcm_datapath #(
  parameter int NUM_BUFFERS = 16,
  parameter int BLOCK_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bbcm_pkg::ctl_t        ctl,
  output bbcm_pkg::sts_t        sts,
  input  logic [1:0]            in_cmd,
  input  logic [31:0]           in_block,
  input  logic [3:0]            in_index,
  input  logic                  in_dirty,
  output logic [2:0]            res_status,
  output logic [3:0]            res_slot,
  output logic [31:0]           res_tag,
  output logic                  res_need,
  output logic                  res_last
);
  localparam int IW = $clog2(NUM_BUFFERS);
  localparam int CW = $clog2(NUM_BUFFERS + 1);

  logic [BLOCK_BITS-1:0] slot_tag [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] slot_valid, slot_locked, slot_dw;
  logic [IW-1:0] free_order [NUM_BUFFERS];
  logic [CW-1:0] free_count;

  logic [1:0]            r_cmd;
  logic [BLOCK_BITS-1:0] r_blk;
  logic [3:0]            r_idx;
  logic                  r_dirty;
  logic [CW-1:0]         scan;
  logic [CW-1:0]         pos;   // search / shift position
  logic [IW-1:0]         sel;   // slot reported

  logic [IW-1:0] scan_i, idx_i, head;
  logic [BLOCK_BITS-1:0] blk_ext;

  assign scan_i = scan[IW-1:0];
  assign idx_i  = IW'(r_idx);
  assign head   = free_order[0];
  assign blk_ext = (BLOCK_BITS > 32) ? BLOCK_BITS'({32'd0, in_block})
                                      : BLOCK_BITS'(in_block);

  assign sts.scan_done  = (scan == CW'(NUM_BUFFERS));
  assign sts.match      = !sts.scan_done && (slot_tag[scan_i] == r_blk);
  assign sts.locked     = (r_cmd == bbcm_pkg::CMD_GET) ? slot_locked[scan_i]
                                                       : slot_locked[idx_i];
  assign sts.head_dirty = slot_dw[head];
  assign sts.free_empty = (free_count == '0);
  assign sts.idx_bad    = ({1'b0, r_idx} >= 5'(NUM_BUFFERS));
  assign sts.srch_found = (pos < free_count) && (free_order[pos[IW-1:0]] == sel);
  assign sts.shift_done = (pos + CW'(1) >= free_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= '0;
      slot_locked <= '0;
      slot_dw     <= '0;
      free_count  <= CW'(NUM_BUFFERS);
      scan        <= '0;
      pos         <= '0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        slot_tag[i]   <= BLOCK_BITS'(i);
        free_order[i] <= IW'(NUM_BUFFERS - 1 - i);
      end
    end else begin
      if (ctl.load) begin
        r_cmd   <= in_cmd;
        r_blk   <= blk_ext;
        r_idx   <= in_index;
        r_dirty <= in_dirty;
      end
      if (ctl.scan_clr) scan <= '0;
      else if (ctl.scan_step) scan <= scan + CW'(1);
      if (ctl.do_hit) begin
        slot_locked[scan_i] <= 1'b1;
        sel <= scan_i;
        pos <= '0;
      end
      if (ctl.srch_step) pos <= pos + CW'(1);
      if (ctl.do_wb) begin
        slot_dw[head] <= 1'b0;
        sel <= head;
        for (int i = 0; i < NUM_BUFFERS - 1; i++)
          if (CW'(i + 1) < free_count) free_order[i] <= free_order[i + 1];
        free_order[free_count[IW-1:0] - IW'(1)] <= head;
      end
      if (ctl.do_miss) begin
        slot_locked[head] <= 1'b1;
        slot_valid[head]  <= 1'b0;
        slot_tag[head]    <= r_blk;
        sel <= head;
        pos <= '0;
      end
      if (ctl.shift_step) begin
        if (!sts.shift_done) begin
          free_order[pos[IW-1:0]] <= free_order[pos[IW-1:0] + IW'(1)];
          pos <= pos + CW'(1);
        end else begin
          free_count <= free_count - CW'(1);
        end
      end
      if (ctl.do_fill) begin
        slot_valid[idx_i] <= 1'b1;
        sel <= idx_i;
      end
      if (ctl.do_release) begin
        sel <= idx_i;
        if (r_dirty) slot_dw[idx_i] <= 1'b1;
        slot_locked[idx_i] <= 1'b0;
        free_count <= free_count + CW'(1);
        if (slot_valid[idx_i]) begin
          free_order[free_count[IW-1:0]] <= idx_i;
        end else begin
          for (int i = 1; i < NUM_BUFFERS; i++)
            free_order[i] <= free_order[i - 1];
          free_order[0] <= idx_i;
        end
      end
    end
  end

  // result register; the reported slot and its bits are taken before the update
  logic [IW-1:0] rs;
  always_comb begin
    unique case (ctl.res_st)
      bbcm_pkg::ST_HIT, bbcm_pkg::ST_BUSY: rs = scan_i;
      bbcm_pkg::ST_WB, bbcm_pkg::ST_MISS:  rs = head;
      default:                             rs = idx_i;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      res_status <= ctl.res_st;
      res_last   <= ctl.res_last;
      res_slot   <= 4'(rs);
      res_tag    <= 32'(slot_tag[rs]);
      res_need   <= !slot_valid[rs];
      unique case (ctl.res_st)
        bbcm_pkg::ST_NOFREE: begin
          res_slot <= '0; res_tag <= '0; res_need <= 1'b0;
        end
        bbcm_pkg::ST_MISS: begin
          res_tag <= 32'(r_blk); res_need <= 1'b1;
        end
        bbcm_pkg::ST_WB, bbcm_pkg::ST_DONE: begin
          if (ctl.res_st == bbcm_pkg::ST_WB || r_cmd == bbcm_pkg::CMD_FILL)
            res_need <= 1'b0;
        end
        bbcm_pkg::ST_BADIDX: begin
          res_slot <= r_idx;
          if (sts.idx_bad) begin
            res_tag <= '0; res_need <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### rtl/core/bbcm_ctrl.sv
// ----------------------------------------------------------------------------
// bbcm_ctrl
// Command sequencer: scan, victim walk, free list upkeep and result hand-off.
// ----------------------------------------------------------------------------
module bbcm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_cmd,
  output logic             out_valid,
  input  logic             out_stall,
  input  bbcm_pkg::sts_t   sts,
  output bbcm_pkg::ctl_t   ctl
);
  bbcm_pkg::state_t state, state_next;
  logic [1:0] cmd_r;
  logic       ovalid, ovalid_next;

  // hold each result until taken; result steps wait on it
  logic out_free;
  assign out_free  = !ovalid || !out_stall;
  assign out_valid = ovalid;
  assign in_stall  = (state != bbcm_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bbcm_pkg::S_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
    if (state == bbcm_pkg::S_IDLE && in_valid) cmd_r <= in_cmd;
  end

  always_comb begin
    ctl = '0;
    ctl.res_st = bbcm_pkg::ST_DONE;
    state_next = state;
    ovalid_next = ovalid && out_stall;
    unique case (state)
      bbcm_pkg::S_IDLE: begin
        if (in_valid && in_cmd != bbcm_pkg::CMD_NONE) begin
          ctl.load = 1'b1;
          ctl.scan_clr = 1'b1;
          state_next = (in_cmd == bbcm_pkg::CMD_GET) ? bbcm_pkg::S_SCAN
                                                     : bbcm_pkg::S_OUT;
        end
      end
      bbcm_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          state_next = bbcm_pkg::S_VICTIM;
        end else if (sts.match) begin
          if (out_free) begin
            ctl.res_load = 1'b1;
            ctl.res_last = 1'b1;
            ovalid_next = 1'b1;
            if (sts.locked) begin
              ctl.res_st = bbcm_pkg::ST_BUSY;
              state_next = bbcm_pkg::S_IDLE;
            end else begin
              ctl.res_st = bbcm_pkg::ST_HIT;
              ctl.do_hit = 1'b1;
              state_next = bbcm_pkg::S_FREESRCH;
            end
          end
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      bbcm_pkg::S_VICTIM: begin
        if (out_free) begin
          ctl.res_load = 1'b1;
          ovalid_next = 1'b1;
          if (sts.free_empty) begin
            ctl.res_st = bbcm_pkg::ST_NOFREE;
            ctl.res_last = 1'b1;
            state_next = bbcm_pkg::S_IDLE;
          end else if (sts.head_dirty) begin
            ctl.res_st = bbcm_pkg::ST_WB;
            ctl.do_wb = 1'b1;
          end else begin
            ctl.res_st = bbcm_pkg::ST_MISS;
            ctl.res_last = 1'b1;
            ctl.do_miss = 1'b1;
            state_next = bbcm_pkg::S_SHIFT;
          end
        end
      end
      bbcm_pkg::S_FREESRCH: begin
        if (sts.srch_found) state_next = bbcm_pkg::S_SHIFT;
        else ctl.srch_step = 1'b1;
      end
      bbcm_pkg::S_SHIFT: begin
        ctl.shift_step = 1'b1;
        if (sts.shift_done) state_next = bbcm_pkg::S_IDLE;
      end
      bbcm_pkg::S_OUT: begin
        if (out_free) begin
          ctl.res_load = 1'b1;
          ctl.res_last = 1'b1;
          ovalid_next = 1'b1;
          state_next = bbcm_pkg::S_IDLE;
          if (sts.idx_bad) begin
            ctl.res_st = bbcm_pkg::ST_BADIDX;
          end else if (cmd_r == bbcm_pkg::CMD_FILL) begin
            ctl.do_fill = 1'b1;
          end else if (!sts.locked) begin
            ctl.res_st = bbcm_pkg::ST_BADIDX;
          end else begin
            ctl.do_release = 1'b1;
          end
        end
      end
      default: state_next = bbcm_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> state == bbcm_pkg::S_IDLE) else $error("load while busy");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (ovalid && out_stall) |-> !ctl.res_load) else $error("result overwritten");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.do_hit, ctl.do_wb, ctl.do_miss, ctl.do_release, ctl.do_fill}))
    else $error("two updates at once");
`endif
endmodule

### rtl/core/block_buffer_cache_manager.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_manager
// Buffer pool tag manager with LRU free list (get / release / fill done).
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  request  | in  | cmd, block_number, buffer_index, mark_dirty
//  result   | out | status, slot, tag_block, need_read, last
//
//  A get scans the tags one slot a cycle; on a miss it then emits one result a
//  cycle per victim while the result is not stalled (up to NUM_BUFFERS + 1
//  results), and on a hit or a miss it compacts the free list one entry a cycle.
//  Reset: synchronous; the tag store and free list load their start values.
//  A stalled result holds the sequencer; one request is worked at a time.
module block_buffer_cache_manager #(
  parameter int NUM_BUFFERS = 16,
  parameter int BLOCK_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] block_number,
  input  logic [3:0]  buffer_index,
  input  logic        mark_dirty,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [3:0]  slot,
  output logic [31:0] tag_block,
  output logic        need_read,
  output logic        last
);
  bbcm_pkg::ctl_t ctl;
  bbcm_pkg::sts_t sts;

  bbcm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_cmd(cmd),
    .out_valid, .out_stall, .sts, .ctl
  );

  bbcm_datapath #(.NUM_BUFFERS(NUM_BUFFERS), .BLOCK_BITS(BLOCK_BITS)) u_dp (
    .clk, .rst, .ctl, .sts,
    .in_cmd(cmd), .in_block(block_number), .in_index(buffer_index),
    .in_dirty(mark_dirty),
    .res_status(status), .res_slot(slot), .res_tag(tag_block),
    .res_need(need_read), .res_last(last)
  );
endmodule

### verif/tb_block_buffer_cache_manager.sv
// ----------------------------------------------------------------------------
// tb_block_buffer_cache_manager
// Drives get, release and fill-done requests into the buffer cache manager,
// predicts every result from a local model of tags, locks, delayed-write
// marks and the LRU free list, and compares results in order.
// ----------------------------------------------------------------------------
module tb_block_buffer_cache_manager;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBUF = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    bbcm_pkg::status_t st;
    logic [3:0]        slot;
    logic [31:0]       tag;
    logic              need;
    logic              last;
  } cache_result_t;

  class cache_scoreboard;
    logic [31:0] tag_q[NBUF];
    bit valid_q[NBUF];
    bit locked_q[NBUF];
    bit dirty_q[NBUF];
    int free_list[$];
    cache_result_t pending[$];
    int errors;

    function void clear();
      for (int i = 0; i < NBUF; i++) begin
        tag_q[i] = 32'(i);
        valid_q[i] = 0;
        locked_q[i] = 0;
        dirty_q[i] = 0;
      end
      free_list.delete();
      for (int i = NBUF - 1; i >= 0; i--) free_list.push_back(i);
      pending.delete();
      errors = 0;
    endfunction

    function void push(bbcm_pkg::status_t st, int s, logic [31:0] tg, bit nd, bit lst);
      cache_result_t r;
      r.st = st;
      r.slot = 4'(s);
      r.tag = tg;
      r.need = nd;
      r.last = lst;
      pending.push_back(r);
    endfunction

    function void note_request(bbcm_pkg::cmd_t c, logic [31:0] blk, logic [3:0] idx,
                               bit dty);
      int v;
      if (c == bbcm_pkg::CMD_GET) begin
        for (int i = 0; i < NBUF; i++) begin
          if (tag_q[i] == blk) begin
            if (locked_q[i]) begin
              push(bbcm_pkg::ST_BUSY, i, tag_q[i], !valid_q[i], 1'b1);
            end else begin
              locked_q[i] = 1;
              foreach (free_list[p]) if (free_list[p] == i) begin
                free_list.delete(p);
                break;
              end
              push(bbcm_pkg::ST_HIT, i, tag_q[i], !valid_q[i], 1'b1);
            end
            return;
          end
        end
        while (free_list.size() > 0) begin
          v = free_list.pop_front();
          if (dirty_q[v]) begin
            push(bbcm_pkg::ST_WB, v, tag_q[v], 1'b0, 1'b0);
            dirty_q[v] = 0;
            free_list.push_back(v);
          end else begin
            locked_q[v] = 1;
            valid_q[v] = 0;
            tag_q[v] = blk;
            push(bbcm_pkg::ST_MISS, v, blk, 1'b1, 1'b1);
            return;
          end
        end
        push(bbcm_pkg::ST_NOFREE, 0, 32'd0, 1'b0, 1'b1);
      end else if (c == bbcm_pkg::CMD_FILL) begin
        valid_q[idx] = 1;
        push(bbcm_pkg::ST_DONE, int'(idx), tag_q[idx], 1'b0, 1'b1);
      end else if (c == bbcm_pkg::CMD_RELEASE) begin
        if (!locked_q[idx]) begin
          push(bbcm_pkg::ST_BADIDX, int'(idx), tag_q[idx], !valid_q[idx], 1'b1);
          return;
        end
        if (dty) dirty_q[idx] = 1;
        if (valid_q[idx]) free_list.push_back(int'(idx));
        else free_list.push_front(int'(idx));
        locked_q[idx] = 0;
        push(bbcm_pkg::ST_DONE, int'(idx), tag_q[idx], !valid_q[idx], 1'b1);
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(cache_result_t got);
      cache_result_t w;
      if (pending.size() == 0) begin
        report("unexpected result", 32'(got.slot), 32'd0);
        return;
      end
      w = pending.pop_front();
      if (got.st != w.st) report("status", 32'(got.st), 32'(w.st));
      if (got.slot != w.slot) report("slot", 32'(got.slot), 32'(w.slot));
      if (got.tag != w.tag) report("tag_block", got.tag, w.tag);
      if (got.need != w.need) report("need_read", 32'(got.need), 32'(w.need));
      if (got.last != w.last) report("last", 32'(got.last), 32'(w.last));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0, in_stall, out_valid;
  logic [1:0] cmd = bbcm_pkg::CMD_NONE;
  logic [31:0] block_number = 0;
  logic [3:0] buffer_index = 0;
  logic mark_dirty = 0;
  logic [2:0] status;
  logic [3:0] slot;
  logic [31:0] tag_block;
  logic need_read, last;

  cache_scoreboard sb;
  int send_idle_pct = 12, recv_idle_pct = 51;
  int idle_cycles = 0;
  logic [31:0] hot_blocks[8];

  block_buffer_cache_manager dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // receiver: check at each edge, then pick the next stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result(cache_result_t'({status, slot, tag_block, need_read, last}));
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // valid stays up after an accept until the next request or an idle cycle
  task automatic send_request(bbcm_pkg::cmd_t c, logic [31:0] blk, logic [3:0] idx,
                              bit dty);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    cmd <= c;
    block_number <= blk;
    buffer_index <= idx;
    mark_dirty <= dty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(c, blk, idx, dty);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 40)
        send_request(bbcm_pkg::CMD_GET,
                     (r < 8) ? $urandom : hot_blocks[$urandom_range(7)],
                     4'($urandom), 1'($urandom));
      else if (r < 75)
        send_request(bbcm_pkg::CMD_RELEASE, $urandom, 4'($urandom), 1'($urandom));
      else if (r < 95)
        send_request(bbcm_pkg::CMD_FILL, $urandom, 4'($urandom), 1'($urandom));
      else
        send_request(bbcm_pkg::CMD_NONE, $urandom, 4'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    for (int i = 0; i < 8; i++) hot_blocks[i] = (i < 4) ? 32'(i) : $urandom;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, busy, dirty writeback, empty pool, bad release
    send_request(bbcm_pkg::CMD_GET, 32'hFFFF_FFFF, 4'd0, 1'b0);
    send_request(bbcm_pkg::CMD_GET, 32'hFFFF_FFFF, 4'd0, 1'b0);
    send_request(bbcm_pkg::CMD_FILL, 32'd0, 4'hF, 1'b0);
    send_request(bbcm_pkg::CMD_RELEASE, 32'd0, 4'hF, 1'b1);
    send_request(bbcm_pkg::CMD_RELEASE, 32'd0, 4'hF, 1'b0);
    send_request(bbcm_pkg::CMD_GET, 32'd3, 4'd0, 1'b0);
    send_request(bbcm_pkg::CMD_RELEASE, 32'd0, 4'd3, 1'b1);
    send_request(bbcm_pkg::CMD_NONE, 32'h5A5A_A5A5, 4'hA, 1'b1);
    for (int i = 0; i < 17; i++)
      send_request(bbcm_pkg::CMD_GET, 32'h100 + 32'(i), 4'd0, 1'b0);
    for (int i = 0; i < NBUF; i++)
      send_request(bbcm_pkg::CMD_RELEASE, 32'd0, 4'(i), 1'b1);
    drain();
    random_phase(80);
    drain();
    send_idle_pct = 51;
    recv_idle_pct = 12;
    random_phase(80);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(80);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/core/bbcm_pkg.sv
rtl/core/bbcm_datapath.sv
rtl/core/bbcm_ctrl.sv
rtl/core/block_buffer_cache_manager.sv
verif/tb_block_buffer_cache_manager.sv
